>>> rtl/tca_pkg.sv
package tca_pkg;

	localparam int SIDE_BITS_DEF = 12;
	localparam int AREA_BITS     = 25;
	localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

	typedef logic [1:0] shape_t;

	localparam shape_t SHAPE_EQUI = 2'd0;
	localparam shape_t SHAPE_ISO  = 2'd1;
	localparam shape_t SHAPE_SCAL = 2'd2;

	// Side information that travels alongside the arithmetic.
	typedef struct packed {
		shape_t shape;
		logic   tri_ok;
	} meta_t;

endpackage

>>> rtl/tca_front.sv
module tca_front
	import tca_pkg::*;
#(
	parameter int SIDE_BITS = SIDE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [SIDE_BITS-1:0] a,
	input  logic [SIDE_BITS-1:0] b,
	input  logic [SIDE_BITS-1:0] c,
	output logic                 valid_s1,
	output meta_t                meta_s1,
	output logic [SIDE_BITS+1:0] f0_s1,
	output logic [SIDE_BITS:0]   f1_s1,
	output logic [SIDE_BITS:0]   f2_s1,
	output logic [SIDE_BITS:0]   f3_s1
);

	localparam int FW = SIDE_BITS + 2;

	logic [FW-1:0] ax, bx, cx, sum, d1, d2, d3;
	logic          ok1, ok2, ok3, tri_ok;
	shape_t        shape;

	always_comb begin
		ax  = FW'(a);
		bx  = FW'(b);
		cx  = FW'(c);
		sum = ax + bx + cx;
		d1  = bx + cx - ax;
		d2  = ax + cx - bx;
		d3  = ax + bx - cx;
		ok1 = !d1[FW-1] && (d1 != '0);
		ok2 = !d2[FW-1] && (d2 != '0);
		ok3 = !d3[FW-1] && (d3 != '0);
		tri_ok = ok1 && ok2 && ok3;
		if (a == b && b == c) begin
			shape = SHAPE_EQUI;
		end else if (a == b || a == c || b == c) begin
			shape = SHAPE_ISO;
		end else begin
			shape = SHAPE_SCAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.shape  <= shape;
			meta_s1.tri_ok <= tri_ok;
			f0_s1 <= tri_ok ? sum : '0;
			f1_s1 <= tri_ok ? d1[FW-2:0] : '0;
			f2_s1 <= tri_ok ? d2[FW-2:0] : '0;
			f3_s1 <= tri_ok ? d3[FW-2:0] : '0;
		end
	end

endmodule

>>> rtl/tca_mult.sv
module tca_mult
	import tca_pkg::*;
#(
	parameter int SIDE_BITS = SIDE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     valid_s1,
	input  meta_t                    meta_s1,
	input  logic [SIDE_BITS+1:0]     f0_s1,
	input  logic [SIDE_BITS:0]       f1_s1,
	input  logic [SIDE_BITS:0]       f2_s1,
	input  logic [SIDE_BITS:0]       f3_s1,
	output logic                     valid_s4,
	output meta_t                    meta_s4,
	output logic [4*SIDE_BITS+4:0]   prod_s4
);

	localparam int XW = 2 * SIDE_BITS + 3;
	localparam int YW = 2 * SIDE_BITS + 2;
	localparam int HL = YW / 2;
	localparam int HH = YW - HL;
	localparam int PW = 4 * SIDE_BITS + 5;

	logic [XW-1:0]    x_s2;
	logic [YW-1:0]    y_s2;
	logic [XW+HL-1:0] pp_lo_s3;
	logic [XW+HH-1:0] pp_hi_s3;
	logic             valid_s2, valid_s3;
	meta_t            meta_s2, meta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// The wide product is split into two partial products over the low and
	// high halves of the second factor, and summed in the following stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2  <= meta_s1;
			x_s2     <= XW'(f0_s1) * XW'(f1_s1);
			y_s2     <= YW'(f2_s1) * YW'(f3_s1);
			meta_s3  <= meta_s2;
			pp_lo_s3 <= (XW+HL)'(x_s2) * (XW+HL)'(y_s2[HL-1:0]);
			pp_hi_s3 <= (XW+HH)'(x_s2) * (XW+HH)'(y_s2[YW-1:HL]);
			meta_s4  <= meta_s3;
			prod_s4  <= PW'(pp_lo_s3) + (PW'(pp_hi_s3) << HL);
		end
	end

endmodule

>>> rtl/tca_sqrt_step.sv
module tca_sqrt_step
	import tca_pkg::*;
#(
	parameter int PW  = 53,
	parameter int RW  = 27,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          valid_in,
	input  meta_t         meta_in,
	input  logic [PW-1:0] rem_in,
	input  logic [RW-1:0] root_in,
	output logic          valid_sn,
	output meta_t         meta_sn,
	output logic [PW-1:0] rem_sn,
	output logic [RW-1:0] root_sn
);

	// Setting this bit of the root raises its square by root * 2^(BIT+1)
	// plus 2^(2*BIT); the bit is kept when the remainder covers that amount.
	logic [PW-1:0] trial;
	logic          take;

	always_comb begin
		trial = (PW'(root_in) << (BIT + 1)) | (PW'(1) << (2 * BIT));
		take  = rem_in >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (adv) begin
			valid_sn <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_sn <= meta_in;
			rem_sn  <= take ? rem_in - trial : rem_in;
			root_sn <= take ? (root_in | (RW'(1) << BIT)) : root_in;
		end
	end

endmodule

>>> rtl/triangle_classify_area_unit.sv
// Triangle classifier and area unit.
// Input channel: side_a, side_b, side_c with item_valid / item_ready.
// Output channel: shape_class, is_valid, area_x4 with result_valid /
// result_ready. shape_class is 0 for equilateral, 1 for isosceles and 2 for
// scalene; is_valid is set when the sides form a non-degenerate triangle,
// and area_x4 is four times the area, truncated, or zero when invalid.
// The area is the integer square root of Heron's product, found one root
// bit per pipeline stage.
// From an accepted transaction to its result there is one stage for the
// sums, three for the product, one per root bit and one output register.
// One transaction is taken per cycle while the output is not stalled;
// every stage advances together.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and item_ready drops; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline starts empty.
module triangle_classify_area_unit
	import tca_pkg::*;
#(
	parameter int SIDE_BITS = SIDE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [SIDE_BITS-1:0] side_a,
	input  logic [SIDE_BITS-1:0] side_b,
	input  logic [SIDE_BITS-1:0] side_c,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [1:0]           shape_class,
	output logic                 is_valid,
	output logic [AREA_BITS-1:0] area_x4
);

	localparam int PW = 4 * SIDE_BITS + 5;
	localparam int RW = 2 * SIDE_BITS + 3;
	localparam int CW = (RW > AREA_BITS) ? RW : AREA_BITS;

	logic                 adv;
	logic                 valid_s1, valid_s4;
	meta_t                meta_s1, meta_s4;
	logic [SIDE_BITS+1:0] f0_s1;
	logic [SIDE_BITS:0]   f1_s1, f2_s1, f3_s1;
	logic [PW-1:0]        prod_s4;

	logic                 valid_st [0:RW];
	meta_t                meta_st  [0:RW];
	logic [PW-1:0]        rem_st   [0:RW];
	logic [RW-1:0]        root_st  [0:RW];

	logic [CW-1:0]        root_w;
	logic [AREA_BITS-1:0] area_sat;

	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;

	tca_front #(
		.SIDE_BITS(SIDE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(item_valid),
		.a       (side_a),
		.b       (side_b),
		.c       (side_c),
		.valid_s1(valid_s1),
		.meta_s1 (meta_s1),
		.f0_s1   (f0_s1),
		.f1_s1   (f1_s1),
		.f2_s1   (f2_s1),
		.f3_s1   (f3_s1)
	);

	tca_mult #(
		.SIDE_BITS(SIDE_BITS)
	) u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_s1(valid_s1),
		.meta_s1 (meta_s1),
		.f0_s1   (f0_s1),
		.f1_s1   (f1_s1),
		.f2_s1   (f2_s1),
		.f3_s1   (f3_s1),
		.valid_s4(valid_s4),
		.meta_s4 (meta_s4),
		.prod_s4 (prod_s4)
	);

	assign valid_st[0] = valid_s4;
	assign meta_st[0]  = meta_s4;
	assign rem_st[0]   = prod_s4;
	assign root_st[0]  = '0;

	for (genvar j = 0; j < RW; j++) begin : g_root
		tca_sqrt_step #(
			.PW (PW),
			.RW (RW),
			.BIT(RW - 1 - j)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.valid_in(valid_st[j]),
			.meta_in (meta_st[j]),
			.rem_in  (rem_st[j]),
			.root_in (root_st[j]),
			.valid_sn(valid_st[j+1]),
			.meta_sn (meta_st[j+1]),
			.rem_sn  (rem_st[j+1]),
			.root_sn (root_st[j+1])
		);
	end

	always_comb begin
		root_w   = CW'(root_st[RW]);
		area_sat = (root_w > CW'(AREA_MAX)) ? AREA_MAX : root_w[AREA_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_st[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			shape_class <= meta_st[RW].shape;
			is_valid    <= meta_st[RW].tri_ok;
			area_x4     <= area_sat;
		end
	end

	a_invalid_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_valid |-> area_x4 == '0)
		else $error("invalid triangle reported with a non-zero area");

	a_valid_nonzero_area: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_valid |-> area_x4 != '0)
		else $error("valid triangle reported with a zero area");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(valid_st[RW]) && $stable(root_st[RW]))
		else $error("last root stage moved while the output was stalled");

endmodule
